// File: sv/image_pair_difference_metric_top_assert.svh
// Assertion macros for the image pair difference metric block.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef IMAGE_PAIR_DIFFERENCE_METRIC_TOP_ASSERT_SVH
`define IMAGE_PAIR_DIFFERENCE_METRIC_TOP_ASSERT_SVH

// Same-cycle implication.
`define IPDM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ipdm: assertion failed");

// Next-cycle implication.
`define IPDM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ipdm: assertion failed");

`endif

// File: sv/ipdm_pkg.sv
package ipdm_pkg;

    localparam int PIX_W        = 32;
    localparam int BYTE_W       = 8;
    localparam int BYTES        = PIX_W / BYTE_W;
    localparam int BYTE_SUM_W   = 10;
    localparam int ERR_W        = 14;
    localparam int TOTAL_OUT_W  = 48;
    localparam int STEP_W       = 4;

    localparam int ERROR_FRAC_BITS_DEF = 4;
    localparam int TOTAL_WIDTH_DEF     = 48;

    // channel difference with sign, and luma/chroma widths
    localparam int CHAN_DIFF_W = 10;
    localparam int LUMA_W      = 22;
    localparam int LUMA_SQ_W   = 43;
    localparam int CHROMA_W    = 9;
    localparam int SUMSQ_W     = 19;
    localparam int N_BASE_W    = 46;
    localparam int TRIAL_W     = 55;

    localparam int LUMA_R = 2126;
    localparam int LUMA_G = 7152;
    localparam int LUMA_B = 722;

    localparam int DIST_SCALE_W = 27;
    localparam logic [DIST_SCALE_W-1:0] DIST_SCALE = 27'd100000000;

    localparam logic [3:0]        GRAY_MUL     = 4'd10;
    localparam logic [BYTE_W-1:0] GRAY_MAX     = 8'd255;
    localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic {
        MODE_BYTE  = 1'b0,
        MODE_COLOR = 1'b1
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_SQR,
        S_SCALE,
        S_ROOT,
        S_ACC
    } t_state;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_a;
        logic [PIX_W-1:0] pixel_b;
        logic             last_in_frame;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0]       diff_pixel;
        logic [ERR_W-1:0]       pixel_error;
        logic [TOTAL_OUT_W-1:0] error_total;
        logic                   frame_done;
    } t_out_item;

    typedef struct packed {
        logic diff_en;
        logic sqr_en;
        logic scale_en;
    } t_prep_ctl;

endpackage

// File: sv/ipdm_prep.sv
module ipdm_prep #(
    parameter int ERROR_FRAC_BITS = ipdm_pkg::ERROR_FRAC_BITS_DEF,
    parameter int N_W             = ipdm_pkg::N_BASE_W + 2 * ipdm_pkg::ERROR_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  ipdm_pkg::t_prep_ctl                 i_ctl,
    input  logic [ipdm_pkg::PIX_W-1:0]          i_pixel_a,
    input  logic [ipdm_pkg::PIX_W-1:0]          i_pixel_b,
    output logic [ipdm_pkg::PIX_W-1:0]          o_byte_diff,
    output logic [ipdm_pkg::BYTE_SUM_W-1:0]     o_byte_sum,
    output logic [N_W-1:0]                      o_n_val
);

    localparam int SHIFT = 2 * ERROR_FRAC_BITS;

    logic signed [ipdm_pkg::CHAN_DIFF_W-1:0] w_dr, w_dg, w_db, w_da, w_dbb;
    logic signed [ipdm_pkg::LUMA_W:0]        w_luma;
    logic [ipdm_pkg::LUMA_W-1:0]             w_luma_abs;
    logic [ipdm_pkg::CHROMA_W-1:0]           w_da_abs, w_dbb_abs;
    logic [ipdm_pkg::PIX_W-1:0]              w_byte_diff;
    logic [ipdm_pkg::BYTE_SUM_W-1:0]         w_byte_sum;
    logic [2*ipdm_pkg::LUMA_W-1:0]           w_luma_sq;
    logic [2*ipdm_pkg::CHROMA_W-1:0]         w_da_sq, w_dbb_sq;
    logic [ipdm_pkg::SUMSQ_W-1:0]            w_sumsq;
    logic [ipdm_pkg::N_BASE_W-1:0]           w_scaled, w_n_base;

    logic [ipdm_pkg::LUMA_W-1:0]             r_luma_abs;
    logic [ipdm_pkg::CHROMA_W-1:0]           r_da, r_dbb;
    logic [ipdm_pkg::PIX_W-1:0]              r_byte_diff;
    logic [ipdm_pkg::BYTE_SUM_W-1:0]         r_byte_sum;
    logic [ipdm_pkg::LUMA_SQ_W-1:0]          r_luma_sq;
    logic [ipdm_pkg::SUMSQ_W-1:0]            r_sumsq;
    logic [N_W-1:0]                          r_n;

    always_comb begin
        w_dr = $signed({2'b00, i_pixel_a[23:16]}) - $signed({2'b00, i_pixel_b[23:16]});
        w_dg = $signed({2'b00, i_pixel_a[15:8]})  - $signed({2'b00, i_pixel_b[15:8]});
        w_db = $signed({2'b00, i_pixel_a[7:0]})   - $signed({2'b00, i_pixel_b[7:0]});
        w_da  = w_dr - w_dg;
        w_dbb = w_dg - w_db;
        w_luma = (ipdm_pkg::LUMA_W + 1)'(ipdm_pkg::LUMA_R * w_dr + ipdm_pkg::LUMA_G * w_dg
                 + ipdm_pkg::LUMA_B * w_db);
        w_luma_abs = w_luma[ipdm_pkg::LUMA_W] ? ipdm_pkg::LUMA_W'(-w_luma)
                                               : ipdm_pkg::LUMA_W'(w_luma);
        w_da_abs  = w_da[ipdm_pkg::CHAN_DIFF_W-1]  ? ipdm_pkg::CHROMA_W'(-w_da)
                                                   : ipdm_pkg::CHROMA_W'(w_da);
        w_dbb_abs = w_dbb[ipdm_pkg::CHAN_DIFF_W-1] ? ipdm_pkg::CHROMA_W'(-w_dbb)
                                                   : ipdm_pkg::CHROMA_W'(w_dbb);
    end

    always_comb begin
        w_byte_sum = '0;
        for (int i = 0; i < ipdm_pkg::BYTES; i++) begin
            w_byte_diff[i*ipdm_pkg::BYTE_W +: ipdm_pkg::BYTE_W] =
                (i_pixel_a[i*ipdm_pkg::BYTE_W +: ipdm_pkg::BYTE_W] >
                 i_pixel_b[i*ipdm_pkg::BYTE_W +: ipdm_pkg::BYTE_W])
                ? i_pixel_a[i*ipdm_pkg::BYTE_W +: ipdm_pkg::BYTE_W]
                  - i_pixel_b[i*ipdm_pkg::BYTE_W +: ipdm_pkg::BYTE_W]
                : i_pixel_b[i*ipdm_pkg::BYTE_W +: ipdm_pkg::BYTE_W]
                  - i_pixel_a[i*ipdm_pkg::BYTE_W +: ipdm_pkg::BYTE_W];
            w_byte_sum = w_byte_sum + ipdm_pkg::BYTE_SUM_W'(
                w_byte_diff[i*ipdm_pkg::BYTE_W +: ipdm_pkg::BYTE_W]);
        end
    end

    assign w_luma_sq = r_luma_abs * r_luma_abs;
    assign w_da_sq   = r_da * r_da;
    assign w_dbb_sq  = r_dbb * r_dbb;
    assign w_sumsq   = {1'b0, w_da_sq} + {1'b0, w_dbb_sq};
    assign w_scaled  = r_sumsq * ipdm_pkg::DIST_SCALE;
    assign w_n_base  = w_scaled + ipdm_pkg::N_BASE_W'(r_luma_sq);

    always_ff @(posedge i_clk) begin
        if (i_ctl.diff_en) begin
            r_luma_abs  <= w_luma_abs;
            r_da        <= w_da_abs;
            r_dbb       <= w_dbb_abs;
            r_byte_diff <= w_byte_diff;
            r_byte_sum  <= w_byte_sum;
        end
        if (i_ctl.sqr_en) begin
            r_luma_sq <= w_luma_sq[ipdm_pkg::LUMA_SQ_W-1:0];
            r_sumsq   <= w_sumsq;
        end
        if (i_ctl.scale_en) begin
            r_n <= N_W'(w_n_base) << SHIFT;
        end
    end

    assign o_byte_diff = r_byte_diff;
    assign o_byte_sum  = r_byte_sum;
    assign o_n_val     = r_n;

endmodule

// File: sv/ipdm_root.sv
module ipdm_root #(
    parameter int N_W = ipdm_pkg::N_BASE_W + 2 * ipdm_pkg::ERROR_FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [N_W-1:0]               i_n_val,
    output logic [ipdm_pkg::ERR_W-1:0]   o_root,
    output logic                         o_done
);

    localparam int CMP_W = (N_W > ipdm_pkg::TRIAL_W) ? N_W : ipdm_pkg::TRIAL_W;
    localparam logic [ipdm_pkg::TRIAL_W-1:0] UNIT_INIT =
        ipdm_pkg::TRIAL_W'(ipdm_pkg::DIST_SCALE) << (2 * (ipdm_pkg::ERR_W - 1));

    logic                            r_busy;
    logic [ipdm_pkg::STEP_W-1:0]     r_step;
    logic [ipdm_pkg::TRIAL_W-1:0]    r_sq, r_cross, r_unit;
    logic [ipdm_pkg::ERR_W-1:0]      r_root;

    logic [ipdm_pkg::TRIAL_W-1:0]    w_trial, w_cross_sum;
    logic                            w_fit;

    // trial = (root + 2^k)^2 * scale, built from the running square and cross term
    assign w_trial     = r_sq + r_cross + r_unit;
    assign w_fit       = CMP_W'(w_trial) <= CMP_W'(i_n_val);
    assign w_cross_sum = w_fit ? r_cross + (r_unit << 1) : r_cross;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_step == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step  <= ipdm_pkg::STEP_W'(ipdm_pkg::ERR_W - 1);
            r_sq    <= '0;
            r_cross <= '0;
            r_unit  <= UNIT_INIT;
            r_root  <= '0;
        end else if (r_busy) begin
            r_step  <= r_step - 1'b1;
            r_cross <= w_cross_sum >> 1;
            r_unit  <= r_unit >> 2;
            if (w_fit) begin
                r_sq   <= w_trial;
                r_root <= r_root | (ipdm_pkg::ERR_W'(1) << r_step);
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_busy && r_step == '0;

endmodule

// File: sv/image_pair_difference_metric_top.sv
// Pixel pair difference and color distance.
// Input channel (i_in_valid / o_in_ready) takes one pair of ARGB pixels and a
// frame-end flag per transfer; output channel (o_out_valid / i_out_ready)
// gives the difference pixel, the pixel error, the running total and the
// frame-end flag. i_cfg_we / i_cfg_wdata write the metric mode (0 byte
// difference, 1 color distance); write it only while the block is idle.
// Byte mode: per-byte absolute differences and their sum are registered, then
// loaded into the output register. Color mode: setup steps (channel
// differences, squares, scaling), then the add-and-compare root unit, one
// result bit per cycle. One item is in flight at a time, so a new item is
// taken only after the last one has reached the output register.
// The output register holds a finished result, so the next item is taken
// while the receiver stalls; that item waits in its last step until the
// output register frees up.
// Reset (synchronous, active low) clears the mode to 0, the running total to
// zero and drops the output valid. The total saturates and returns to zero
// after the result that ends a frame.
`include "image_pair_difference_metric_top_assert.svh"

module image_pair_difference_metric_top #(
    parameter int ERROR_FRAC_BITS = ipdm_pkg::ERROR_FRAC_BITS_DEF,
    parameter int TOTAL_WIDTH     = ipdm_pkg::TOTAL_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ipdm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ipdm_pkg::t_out_item o_out_data
);

    localparam int N_W   = ipdm_pkg::N_BASE_W + 2 * ERROR_FRAC_BITS;
    localparam int EXT_W = TOTAL_WIDTH + ipdm_pkg::TOTAL_OUT_W;

    ipdm_pkg::t_state               r_state, n_state;
    ipdm_pkg::t_mode                r_mode;
    logic [ipdm_pkg::PIX_W-1:0]     r_pix_a, r_pix_b;
    logic                           r_last;
    logic [TOTAL_WIDTH-1:0]         r_acc;
    logic                           r_out_valid;
    ipdm_pkg::t_out_item            r_out_data;

    ipdm_pkg::t_prep_ctl            w_prep_ctl;
    logic                           w_root_start;
    logic                           w_root_done;
    logic                           w_load_out;
    logic                           w_accept;
    logic [ipdm_pkg::PIX_W-1:0]     w_byte_diff;
    logic [ipdm_pkg::BYTE_SUM_W-1:0] w_byte_sum;
    logic [N_W-1:0]                 w_n_val;
    logic [ipdm_pkg::ERR_W-1:0]     w_root;
    logic [ipdm_pkg::ERR_W-1:0]     w_err;
    logic [ipdm_pkg::ERR_W+3:0]     w_gray_full, w_gray_shift;
    logic [ipdm_pkg::BYTE_W-1:0]    w_gray;
    logic [ipdm_pkg::PIX_W-1:0]     w_diff;
    logic [TOTAL_WIDTH:0]           w_sum;
    logic [TOTAL_WIDTH-1:0]         w_total;
    logic [EXT_W-1:0]               w_total_ext;

    ipdm_prep #(
        .ERROR_FRAC_BITS (ERROR_FRAC_BITS),
        .N_W             (N_W)
    ) u_prep (
        .i_clk       (i_clk),
        .i_ctl       (w_prep_ctl),
        .i_pixel_a   (r_pix_a),
        .i_pixel_b   (r_pix_b),
        .o_byte_diff (w_byte_diff),
        .o_byte_sum  (w_byte_sum),
        .o_n_val     (w_n_val)
    );

    ipdm_root #(
        .N_W (N_W)
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_n_val (w_n_val),
        .o_root  (w_root),
        .o_done  (w_root_done)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ipdm_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ipdm_pkg::S_DIFF;
                end
            end
            ipdm_pkg::S_DIFF: begin
                n_state = (r_mode == ipdm_pkg::MODE_COLOR) ? ipdm_pkg::S_SQR
                                                           : ipdm_pkg::S_ACC;
            end
            ipdm_pkg::S_SQR:   n_state = ipdm_pkg::S_SCALE;
            ipdm_pkg::S_SCALE: n_state = ipdm_pkg::S_ROOT;
            ipdm_pkg::S_ROOT: begin
                if (w_root_done) begin
                    n_state = ipdm_pkg::S_ACC;
                end
            end
            ipdm_pkg::S_ACC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ipdm_pkg::S_IDLE;
                end
            end
            default: n_state = ipdm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready          = 1'b0;
        w_prep_ctl          = '0;
        w_root_start        = 1'b0;
        w_load_out          = 1'b0;
        case (r_state)
            ipdm_pkg::S_IDLE:  o_in_ready = 1'b1;
            ipdm_pkg::S_DIFF:  w_prep_ctl.diff_en = 1'b1;
            ipdm_pkg::S_SQR:   w_prep_ctl.sqr_en = 1'b1;
            ipdm_pkg::S_SCALE: begin
                w_prep_ctl.scale_en = 1'b1;
                w_root_start        = 1'b1;
            end
            ipdm_pkg::S_ACC:   w_load_out = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        w_err        = (r_mode == ipdm_pkg::MODE_COLOR) ? w_root
                                                        : ipdm_pkg::ERR_W'(w_byte_sum);
        w_gray_full  = w_err * ipdm_pkg::GRAY_MUL;
        w_gray_shift = w_gray_full >> ERROR_FRAC_BITS;
        w_gray       = (w_gray_shift > (ipdm_pkg::ERR_W + 4)'(ipdm_pkg::GRAY_MAX))
                       ? ipdm_pkg::GRAY_MAX : w_gray_shift[ipdm_pkg::BYTE_W-1:0];
        w_diff       = (r_mode == ipdm_pkg::MODE_COLOR)
                       ? {ipdm_pkg::ALPHA_OPAQUE, w_gray, w_gray, w_gray} : w_byte_diff;
        w_sum        = {1'b0, r_acc} + (TOTAL_WIDTH + 1)'(w_err);
        w_total      = w_sum[TOTAL_WIDTH] ? '1 : w_sum[TOTAL_WIDTH-1:0];
        w_total_ext  = EXT_W'(w_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ipdm_pkg::S_IDLE;
            r_mode      <= ipdm_pkg::MODE_BYTE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_mode <= ipdm_pkg::t_mode'(i_cfg_wdata);
            end
            if (w_load_out) begin
                r_acc       <= r_last ? '0 : w_total;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix_a <= i_in_data.pixel_a;
            r_pix_b <= i_in_data.pixel_b;
            r_last  <= i_in_data.last_in_frame;
        end
        if (w_load_out) begin
            r_out_data.diff_pixel  <= w_diff;
            r_out_data.pixel_error <= w_err;
            r_out_data.error_total <= w_total_ext[ipdm_pkg::TOTAL_OUT_W-1:0];
            r_out_data.frame_done  <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `IPDM_ASSERT_IMP(a_done_in_root, w_root_done, r_state == ipdm_pkg::S_ROOT)
    `IPDM_ASSERT_NEXT(a_frame_clear, w_load_out && r_last, r_acc == '0)
    `IPDM_ASSERT_NEXT(a_total_no_wrap, w_load_out && !r_last, r_acc >= $past(r_acc))

endmodule
